// File: hdl/base64_stream_encoder_macros.svh
// Assertion helpers shared by the encoder modules.
// Every check is clocked on i_clk and held off while i_rst_n is low.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// The property must hold at every enabled clock edge.
`define B64E_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// The condition must never be seen at an enabled clock edge.
`define B64E_ASSERT_NEVER(lbl, cond, msg) \
    `B64E_ASSERT_ALWAYS(lbl, !(cond), msg)

`endif

// File: hdl/b64e_pkg.sv
`timescale 1ns / 1ps

package b64e_pkg;

    // Bytes held for the group being collected
    localparam logic [1:0] GP_EMPTY = 2'd0;
    localparam logic [1:0] GP_ONE   = 2'd1;
    localparam logic [1:0] GP_TWO   = 2'd2;

    // Number of '=' characters closing a group
    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;

    // Character slots within one group job
    localparam logic [2:0] SLOT_0  = 3'd0;
    localparam logic [2:0] SLOT_1  = 3'd1;
    localparam logic [2:0] SLOT_2  = 3'd2;
    localparam logic [2:0] SLOT_3  = 3'd3;
    localparam logic [2:0] SLOT_CR = 3'd4;
    localparam logic [2:0] SLOT_LF = 3'd5;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    // One group of work handed from the front end to the character engine
    typedef struct packed {
        logic [23:0] bits;  // up to three bytes, first byte in the top bits
        logic [1:0]  pad;   // trailing '=' count
        logic        brk;   // CR LF follows the group
        logic        last;  // group closes the message
    } t_job;

    // Map a six-bit value onto the standard alphabet
    function automatic logic [7:0] f_sym_char(input logic [5:0] six);
        logic [7:0] v;
        logic [7:0] c;
        v = {2'b00, six};
        if (six < 6'd26) begin
            c = 8'h41 + v;
        end else if (six < 6'd52) begin
            c = 8'h61 + v - 8'd26;
        end else if (six < 6'd62) begin
            c = 8'h30 + v - 8'd52;
        end else if (six == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// File: hdl/b64e_front.sv
`timescale 1ns / 1ps
`include "base64_stream_encoder_macros.svh"

module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [5:0]  r_line_groups;
    logic [1:0]  r_group_pos, n_group_pos;
    logic [15:0] r_held, n_held;
    logic [5:0]  r_line_count, n_line_count;
    logic [5:0]  line_inc;
    logic        accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_full;
    assign accept      = i_valid && !i_q_full;
    assign line_inc    = r_line_count + 6'd1;

    // Collect bytes into groups and decide what each beat produces
    always_comb begin
        n_group_pos  = r_group_pos;
        n_held       = r_held;
        n_line_count = r_line_count;
        o_push       = 1'b0;
        o_job        = '0;
        if (accept) begin
            unique case (r_group_pos)
                GP_EMPTY: begin
                    n_held      = {i_data_byte, 8'h00};
                    n_group_pos = GP_ONE;
                    if (i_last_byte) begin
                        o_push     = 1'b1;
                        o_job.bits = {i_data_byte, 16'h0000};
                        o_job.pad  = PAD_TWO;
                    end
                end
                GP_ONE: begin
                    n_held      = {r_held[15:8], i_data_byte};
                    n_group_pos = GP_TWO;
                    if (i_last_byte) begin
                        o_push     = 1'b1;
                        o_job.bits = {r_held[15:8], i_data_byte, 8'h00};
                        o_job.pad  = PAD_ONE;
                    end
                end
                default: begin
                    o_push      = 1'b1;
                    o_job.bits  = {r_held, i_data_byte};
                    o_job.pad   = PAD_NONE;
                    n_group_pos = GP_EMPTY;
                    n_held      = '0;
                    if (r_line_groups != 6'd0) begin
                        if (line_inc == r_line_groups) begin
                            o_job.brk    = 1'b1;
                            n_line_count = '0;
                        end else begin
                            n_line_count = line_inc;
                        end
                    end
                end
            endcase
            // Close the message: clear group and line position
            if (i_last_byte) begin
                o_job.last   = 1'b1;
                n_group_pos  = GP_EMPTY;
                n_held       = '0;
                n_line_count = '0;
            end
        end
    end

    // Hold front-end state and the line length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_groups <= '0;
            r_group_pos   <= GP_EMPTY;
            r_held        <= '0;
            r_line_count  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_line_groups <= i_cfg_data;
            end
            r_group_pos  <= n_group_pos;
            r_held       <= n_held;
            r_line_count <= n_line_count;
        end
    end

    `B64E_ASSERT_NEVER(a_group_pos_range, r_group_pos == 2'd3,
        "group position reached an unused code")

endmodule

// File: hdl/b64e_fifo.sv
`timescale 1ns / 1ps
`include "base64_stream_encoder_macros.svh"

module b64e_fifo
    import b64e_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Store jobs on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `B64E_ASSERT_NEVER(a_push_when_full, i_push && o_full, "job queue overflow")
    `B64E_ASSERT_NEVER(a_pop_when_empty, i_pop && !o_head_valid, "job queue underflow")

endmodule

// File: hdl/b64e_back.sv
`timescale 1ns / 1ps
`include "base64_stream_encoder_macros.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_last
);

    logic [2:0] r_slot, n_slot;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic [2:0] final_slot;
    logic       advance;
    logic       emit;
    logic       at_end;
    logic [7:0] sel_char;

    assign advance    = !r_valid || !i_stall;
    assign emit       = advance && i_head_valid;
    assign final_slot = i_head.brk ? SLOT_LF : SLOT_3;
    assign at_end     = (r_slot == final_slot);
    assign o_pop      = emit && at_end;
    assign n_slot     = at_end ? SLOT_0 : r_slot + 3'd1;

    // Pick the character for the current slot of the head job
    always_comb begin
        unique case (r_slot)
            SLOT_0:  sel_char = f_sym_char(i_head.bits[23:18]);
            SLOT_1:  sel_char = f_sym_char(i_head.bits[17:12]);
            SLOT_2:  sel_char = (i_head.pad == PAD_TWO) ? CHAR_PAD
                                                        : f_sym_char(i_head.bits[11:6]);
            SLOT_3:  sel_char = (i_head.pad != PAD_NONE) ? CHAR_PAD
                                                         : f_sym_char(i_head.bits[5:0]);
            SLOT_CR: sel_char = CHAR_CR;
            SLOT_LF: sel_char = CHAR_LF;
            default: sel_char = CHAR_PAD;
        endcase
    end

    // Step through the slots and hold the output beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= SLOT_0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= i_head_valid;
            end
            if (emit) begin
                r_slot <= n_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= sel_char;
            r_last <= i_head.last && at_end;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_char = r_char;
    assign o_out_last = r_last;

    `B64E_ASSERT_NEVER(a_slot_without_job, (r_slot != SLOT_0) && !i_head_valid,
        "character slot moved with no job at the queue head")
    `B64E_ASSERT_ALWAYS(a_slot_range, r_slot <= SLOT_LF, "character slot out of range")

endmodule

// File: hdl/base64_stream_encoder.sv
`timescale 1ns / 1ps

// Streaming base64 encoder (standard alphabet). A byte beat is taken in any
// cycle in which the job queue between the byte front end and the character
// engine has room; o_stall is simply that queue being full. Every third byte
// of a message, and the final byte, queues one job, and the engine emits
// one character per cycle while a job is queued and i_stall is low, from a
// single output register: four characters per group, two more for a CR LF
// line break. A group's completing byte passes through the job queue and
// the output register before its first character appears. line_groups is
// written over the cfg channel (always ready) and applies to the next group;
// 0 turns line breaks off. No clearing pass is needed after reset.
module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_head_valid;
    t_job q_in_job;
    t_job q_head;

    // Byte front end: grouping, line count, job build
    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_in_job)
    );

    // Job queue decoupling the two sides
    b64e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (q_in_job),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // Character engine
    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_out_last   (o_out_last)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

// One expected character beat: the ASCII code and the end-of-message flag
typedef struct packed {
    logic [7:0] ch;
    logic       last;
} t_enc_char;

// Tracks the encoder state and the characters still owed by the block
class b64_char_scoreboard;
    string      symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [5:0] line_groups = 6'd0;
    logic [1:0] group_pos = b64e_pkg::GP_EMPTY;
    logic [15:0] held = 16'h0000;
    logic [5:0] line_count = 6'd0;
    t_enc_char  owed_chars[$];
    int         errors = 0;

    function void push_raw(input logic [7:0] ch);
        t_enc_char c;
        c.ch = ch;
        c.last = 1'b0;
        owed_chars.push_back(c);
    endfunction

    function void push_sym(input logic [5:0] six);
        push_raw(symbols[int'(six)]);
    endfunction

    // Note an accepted byte beat and queue the characters it releases
    function void take_byte(input logic [7:0] b, input logic last);
        logic [7:0] b0;
        logic [7:0] b1;
        t_enc_char  tail;
        if (group_pos == b64e_pkg::GP_TWO) begin
            b0 = held[15:8];
            b1 = held[7:0];
            push_sym(b0[7:2]);
            push_sym({b0[1:0], b1[7:4]});
            push_sym({b1[3:0], b[7:6]});
            push_sym(b[5:0]);
            group_pos = b64e_pkg::GP_EMPTY;
            held = 16'h0000;
            // count full groups on the line; break when the line fills
            if (line_groups != 6'd0) begin
                line_count = line_count + 6'd1;
                if (line_count == line_groups) begin
                    push_raw(b64e_pkg::CHAR_CR);
                    push_raw(b64e_pkg::CHAR_LF);
                    line_count = 6'd0;
                end
            end
        end else if (group_pos == b64e_pkg::GP_ONE) begin
            held[7:0] = b;
            group_pos = b64e_pkg::GP_TWO;
            if (last) begin
                b0 = held[15:8];
                push_sym(b0[7:2]);
                push_sym({b0[1:0], b[7:4]});
                push_sym({b[3:0], 2'b00});
                push_raw(b64e_pkg::CHAR_PAD);
            end
        end else begin
            held = {b, 8'h00};
            group_pos = b64e_pkg::GP_ONE;
            if (last) begin
                push_sym(b[7:2]);
                push_sym({b[1:0], 4'h0});
                push_raw(b64e_pkg::CHAR_PAD);
                push_raw(b64e_pkg::CHAR_PAD);
            end
        end
        // a final byte always releases characters: flag the last one, clear state
        if (last) begin
            tail = owed_chars.pop_back();
            tail.last = 1'b1;
            owed_chars.push_back(tail);
            group_pos = b64e_pkg::GP_EMPTY;
            held = 16'h0000;
            line_count = 6'd0;
        end
    endfunction

    // Compare one character beat from the block with the oldest owed one
    function void check_char(input logic [7:0] ch, input logic last);
        t_enc_char want;
        if (owed_chars.size() == 0) begin
            $error("unexpected character beat: out_char %h out_last %b", ch, last);
            errors++;
            return;
        end
        want = owed_chars.pop_front();
        if (want.ch !== ch) begin
            $error("out_char mismatch: expected %h, actual %h", want.ch, ch);
            errors++;
        end
        if (want.last !== last) begin
            $error("out_last mismatch: expected %b, actual %b", want.last, last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import b64e_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       chr_valid;
    logic       chr_stall = 1'b0;
    logic [7:0] chr;
    logic       chr_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data = 6'd0;

    b64_char_scoreboard sb;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int cycle_cnt = 0;

    base64_stream_encoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_data_byte (data_byte),
        .i_last_byte (last_byte),
        .o_valid     (chr_valid),
        .i_stall     (chr_stall),
        .o_out_char  (chr),
        .o_out_last  (chr_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every character beat the block hands over
    always @(posedge clk) begin
        if (rst_n && chr_valid && !chr_stall) begin
            sb.check_char(chr, chr_last);
        end
    end

    // Stall the character side: free, light, heavy or periodic stretches
    always @(negedge clk) begin
        cycle_cnt++;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                chr_stall <= 1'b0;
            end
            1: begin
                chr_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                chr_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                chr_stall <= cycle_cnt[2];
            end
        endcase
    end

    // Offer one byte beat, possibly idling first when a burst has run out
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (in_stall);
        sb.take_byte(b, last);
    endtask

    // Drop valid and wait until every owed character has come out
    task automatic drain_output();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.owed_chars.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write the line length while the block is idle
    task automatic set_line_groups(input logic [5:0] lg);
        drain_output();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lg;
        do @(posedge clk); while (!cfg_ready);
        sb.line_groups = lg;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send whole messages of random length until enough bytes have gone
    task automatic send_messages(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                send_byte(8'($urandom_range(0, 255)), i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: break after every group, both paddings, extreme bytes
        set_line_groups(6'd1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        for (int i = 1; i <= 6; i++) begin
            send_byte(8'(i), i == 6);
        end

        // random messages across line lengths, wrapping off among them
        set_line_groups(6'd0);
        send_messages(20);
        set_line_groups(6'd2);
        send_messages(20);
        set_line_groups(6'd3);
        send_messages(20);
        set_line_groups(6'($urandom_range(4, 62)));
        send_messages(20);

        // longest line
        set_line_groups(6'd63);
        send_messages(20);

        set_line_groups(6'd1);
        send_messages(20);

        drain_output();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.owed_chars.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
